// ----- sv/keyed_count_slot_table_core_defines.svh -----
// Assertion helpers shared by the table modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef KEYED_COUNT_SLOT_TABLE_CORE_DEFINES_SVH
`define KEYED_COUNT_SLOT_TABLE_CORE_DEFINES_SVH

`define KCST_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define KCST_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define KCST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/kcst_pkg.sv -----
package kcst_pkg;

	localparam int SLOTS      = 16;
	localparam int COUNT_BITS = 16;
	localparam int ID_BITS    = 8;

	localparam int CMD_BITS    = 2;
	localparam int TYPE_BITS   = 2;
	localparam int IN_ID_BITS  = 8;
	localparam int AMT_BITS    = 16;
	localparam int QTY_BITS    = 16;
	localparam int STATUS_BITS = 3;
	localparam int INDEX_BITS  = 4;
	localparam int OCC_OUT_BITS = 5;

	localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_BITS  = $clog2(SLOTS + 1);
	localparam int WIDE_BITS = ((COUNT_BITS > QTY_BITS) ? COUNT_BITS : QTY_BITS) + 1;

	localparam logic [WIDE_BITS-1:0] COUNT_MAX_W = WIDE_BITS'((64'd1 << COUNT_BITS) - 64'd1);
	localparam logic [WIDE_BITS-1:0] QTY_MAX_W   = WIDE_BITS'((64'd1 << QTY_BITS) - 64'd1);

	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2
	} kcst_cmd_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_ADD,
		OP_REMOVE,
		OP_QUERY
	} kcst_opcode_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_MERGED = 3'd0,
		ST_NEW    = 3'd1,
		ST_FULL   = 3'd2,
		ST_SHORT  = 3'd3,
		ST_DONE   = 3'd4
	} kcst_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MATCH,
		BK_EXEC,
		BK_RES
	} kcst_bstate_t;

	typedef struct packed {
		kcst_opcode_t           op;
		logic [TYPE_BITS-1:0]   item_type;
		logic [ID_BITS-1:0]     item_id;
		logic [AMT_BITS-1:0]    amount;
	} kcst_op_t;

	typedef struct packed {
		kcst_status_t            status;
		logic [INDEX_BITS-1:0]   slot_index;
		logic [QTY_BITS-1:0]     quantity;
		logic [OCC_OUT_BITS-1:0] occupied_slots;
	} kcst_res_t;

	// Lowest set bit of a slot mask: found flag on top, index below.
	function automatic logic [SLOT_BITS:0] first_set(input logic [SLOTS-1:0] v);
		logic [SLOT_BITS:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, SLOT_BITS'(i)};
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/kcst_front.sv -----
`include "keyed_count_slot_table_core_defines.svh"

module kcst_front import kcst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_BITS-1:0]   command,
	input  logic [TYPE_BITS-1:0]  item_type,
	input  logic [IN_ID_BITS-1:0] item_id,
	input  logic [AMT_BITS-1:0]   amount,
	output logic                  q_valid,
	input  logic                  q_ready,
	output kcst_op_t              q_item
);

	kcst_op_t               mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;
	kcst_op_t               op_d;
	kcst_cmd_t              cmd;
	logic                   push;
	logic                   pop;

	assign cmd = kcst_cmd_t'(command);

	// A zero amount turns add and remove into a no-op; unused codes do the same.
	always_comb begin
		op_d.item_type = item_type;
		op_d.item_id   = ID_BITS'(32'(item_id));
		op_d.amount    = amount;
		case (cmd)
			CMD_ADD:    op_d.op = (amount != '0) ? OP_ADD : OP_NOP;
			CMD_REMOVE: op_d.op = (amount != '0) ? OP_REMOVE : OP_NOP;
			CMD_QUERY:  op_d.op = OP_QUERY;
			default:    op_d.op = OP_NOP;
		endcase
	end

	assign in_ready = (cnt_q != QCNT_BITS'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= op_d;
		end
	end

	`KCST_CHECK(a_cnt_range, cnt_q <= QCNT_BITS'(QDEPTH), "queue fill count out of range")
	`KCST_NEXT(a_cnt_push, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "push lost")
	`KCST_NEXT(a_cnt_pop, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "pop lost")

endmodule

// ----- sv/kcst_back.sv -----
`include "keyed_count_slot_table_core_defines.svh"

module kcst_back import kcst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_ready,
	input  kcst_op_t  q_item,
	output logic      m_valid,
	input  logic      m_ready,
	output kcst_res_t m_res
);

	kcst_bstate_t              state_q;
	kcst_bstate_t              state_d;
	kcst_op_t                  op_q;
	logic [SLOTS-1:0]          mask_q;
	logic [SLOT_BITS:0]        empty_q;
	logic [QTY_BITS-1:0]       rem_q;
	logic [QTY_BITS-1:0]       total_q;

	logic [SLOTS-1:0]          slot_valid_q;
	logic [TYPE_BITS-1:0]      slot_type_q  [SLOTS];
	logic [ID_BITS-1:0]        slot_id_q    [SLOTS];
	logic [COUNT_BITS-1:0]     slot_count_q [SLOTS];
	logic [OCC_BITS-1:0]       occ_q;

	kcst_status_t              res_status_q;
	logic [SLOT_BITS-1:0]      res_index_q;
	logic [QTY_BITS-1:0]       res_qty_q;
	logic                      out_valid_q;
	kcst_res_t                 out_q;

	logic [SLOTS-1:0]          match_v;
	logic [SLOT_BITS:0]        hit;
	logic                      hit_found;
	logic [SLOT_BITS-1:0]      hit_idx;
	logic [COUNT_BITS-1:0]     hit_count;
	logic [WIDE_BITS-1:0]      cnt_w;
	logic [WIDE_BITS-1:0]      amt_w;
	logic [WIDE_BITS-1:0]      rem_w;
	logic [WIDE_BITS-1:0]      add_sum;
	logic [WIDE_BITS-1:0]      qry_sum;
	logic [COUNT_BITS-1:0]     add_val;
	logic [COUNT_BITS-1:0]     new_val;
	logic                      take_all;

	logic                      finish;
	kcst_status_t              res_status_d;
	logic [SLOT_BITS-1:0]      res_index_d;
	logic [QTY_BITS-1:0]       res_qty_d;
	logic                      wr_en;
	logic                      wr_set;
	logic                      wr_clear;
	logic [SLOT_BITS-1:0]      wr_idx;
	logic [COUNT_BITS-1:0]     wr_count;
	logic                      mask_step;
	logic [QTY_BITS-1:0]       rem_d;
	logic [QTY_BITS-1:0]       total_d;
	logic                      out_load;
	logic [31:0]               idx_ext;
	logic [31:0]               occ_ext;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			match_v[s] = slot_valid_q[s] && (slot_type_q[s] == op_q.item_type)
				&& (slot_id_q[s] == op_q.item_id);
		end
	end

	// The walk visits the remaining matching slots in index order, one per cycle.
	assign hit       = first_set(mask_q);
	assign hit_found = hit[SLOT_BITS];
	assign hit_idx   = hit[SLOT_BITS-1:0];
	assign hit_count = slot_count_q[hit_idx];

	assign cnt_w    = WIDE_BITS'(hit_count);
	assign amt_w    = WIDE_BITS'(op_q.amount);
	assign rem_w    = WIDE_BITS'(rem_q);
	assign add_sum  = cnt_w + amt_w;
	assign qry_sum  = WIDE_BITS'(total_q) + cnt_w;
	assign add_val  = COUNT_BITS'((add_sum > COUNT_MAX_W) ? COUNT_MAX_W : add_sum);
	assign new_val  = COUNT_BITS'((amt_w > COUNT_MAX_W) ? COUNT_MAX_W : amt_w);
	assign take_all = (cnt_w <= rem_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		q_ready      = 1'b0;
		finish       = 1'b0;
		res_status_d = ST_DONE;
		res_index_d  = '0;
		res_qty_d    = '0;
		wr_en        = 1'b0;
		wr_set       = 1'b0;
		wr_clear     = 1'b0;
		wr_idx       = hit_idx;
		wr_count     = add_val;
		mask_step    = 1'b0;
		rem_d        = rem_q;
		total_d      = total_q;
		out_load     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					state_d = BK_MATCH;
				end
			end
			BK_MATCH: begin
				state_d = BK_EXEC;
			end
			BK_EXEC: begin
				case (op_q.op)
					OP_ADD: begin
						finish = 1'b1;
						if (hit_found) begin
							wr_en        = 1'b1;
							res_status_d = ST_MERGED;
							res_index_d  = hit_idx;
						end else if (empty_q[SLOT_BITS]) begin
							wr_en        = 1'b1;
							wr_set       = 1'b1;
							wr_idx       = empty_q[SLOT_BITS-1:0];
							wr_count     = new_val;
							res_status_d = ST_NEW;
							res_index_d  = empty_q[SLOT_BITS-1:0];
						end else begin
							res_status_d = ST_FULL;
						end
					end
					OP_REMOVE: begin
						if (hit_found && (rem_q != '0)) begin
							wr_en     = 1'b1;
							mask_step = 1'b1;
							if (take_all) begin
								wr_clear = 1'b1;
								rem_d    = QTY_BITS'(rem_w - cnt_w);
							end else begin
								wr_count = COUNT_BITS'(cnt_w - rem_w);
								rem_d    = '0;
							end
						end else begin
							finish       = 1'b1;
							res_status_d = (rem_q != '0) ? ST_SHORT : ST_DONE;
							res_qty_d    = rem_q;
						end
					end
					OP_QUERY: begin
						if (hit_found) begin
							mask_step = 1'b1;
							total_d   = (qry_sum > QTY_MAX_W) ? QTY_MAX_W[QTY_BITS-1:0]
								: QTY_BITS'(qry_sum);
						end else begin
							finish    = 1'b1;
							res_qty_d = total_q;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
				if (finish) begin
					state_d = BK_RES;
				end
			end
			BK_RES: begin
				if (!out_valid_q || m_ready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			occ_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en && wr_set) begin
				slot_valid_q[wr_idx] <= 1'b1;
				occ_q                <= occ_q + OCC_BITS'(1);
			end else if (wr_en && wr_clear) begin
				slot_valid_q[wr_idx] <= 1'b0;
				occ_q                <= occ_q - OCC_BITS'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid) begin
			op_q    <= q_item;
			rem_q   <= q_item.amount;
			total_q <= '0;
		end else if (state_q == BK_EXEC) begin
			rem_q   <= rem_d;
			total_q <= total_d;
		end
		if (state_q == BK_MATCH) begin
			mask_q  <= match_v;
			empty_q <= first_set(~slot_valid_q);
		end else if (mask_step) begin
			mask_q <= mask_q & ~(SLOTS'(1) << hit_idx);
		end
		if (wr_en && !wr_clear) begin
			slot_count_q[wr_idx] <= wr_count;
			if (wr_set) begin
				slot_type_q[wr_idx] <= op_q.item_type;
				slot_id_q[wr_idx]   <= op_q.item_id;
			end
		end
		if (finish) begin
			res_status_q <= res_status_d;
			res_index_q  <= res_index_d;
			res_qty_q    <= res_qty_d;
		end
		if (out_load) begin
			out_q.status         <= res_status_q;
			out_q.slot_index     <= idx_ext[INDEX_BITS-1:0];
			out_q.quantity       <= res_qty_q;
			out_q.occupied_slots <= occ_ext[OCC_OUT_BITS-1:0];
		end
	end

	assign idx_ext = 32'(res_index_q);
	assign occ_ext = 32'(occ_q);
	assign m_valid = out_valid_q;
	assign m_res   = out_q;

	`KCST_CHECK(a_occ_count, occ_q == OCC_BITS'($countones(slot_valid_q)), "occupancy drift")
	`KCST_IMPLIES(a_single_key, state_q == BK_EXEC, $onehot0(mask_q), "key held in two slots")
	`KCST_NEXT(a_add_one_step, state_q == BK_EXEC && op_q.op == OP_ADD, state_q == BK_RES,
		"add did not finish in one step")

endmodule

// ----- sv/keyed_count_slot_table_core.sv -----
// Keyed count slot table: 16 slots of {type, id, count} cleared at once by reset, so items
// are taken right after reset with no clearing pass. Items enter a two-deep queue and run
// on a sequencer that handles one item at a time: fetch, a parallel key compare over all
// slots, then one step per slot touched, then the result is placed in the output register.
// Add, query of a missing key and ignored commands finish in one execute step; remove and query
// take one more step for each matching slot visited (a key lives in at most one slot). The
// sequencer walks matching slots one per cycle and loads each result before the next item.
// Counts saturate at their maximum and query totals at 65535.
`include "keyed_count_slot_table_core_defines.svh"

module keyed_count_slot_table_core import kcst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // command
	input  logic [31:0] s_tdata,   // item_type [1:0], item_id [9:2], amount [25:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [2:0]  m_tuser,   // status
	output logic [31:0] m_tdata    // slot_index [3:0], quantity [19:4], occupied_slots [24:20]
);

	logic      q_valid;
	logic      q_ready;
	kcst_op_t  q_item;
	kcst_res_t res;

	kcst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.command   (s_tuser),
		.item_type (s_tdata[1:0]),
		.item_id   (s_tdata[9:2]),
		.amount    (s_tdata[25:10]),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	kcst_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {7'd0, res.occupied_slots, res.quantity, res.slot_index};

endmodule

// ----- bench/kcst_checker.sv -----
`timescale 1ns / 100ps

module kcst_checker import kcst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,   // command
	input  logic [31:0] s_tdata,   // item_type [1:0], item_id [9:2], amount [25:10]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [2:0]  m_tuser,   // status
	input  logic [31:0] m_tdata,   // slot_index [3:0], quantity [19:4], occupied_slots [24:20]
	output int          pending,
	output int          mismatches
);

	localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;
	localparam longint unsigned QTY_TOP   = (64'd1 << QTY_BITS) - 64'd1;

	// Shadow copy of the slot table.
	logic                  slot_used   [SLOTS];
	logic [TYPE_BITS-1:0]  slot_kind   [SLOTS];
	logic [ID_BITS-1:0]    slot_key_id [SLOTS];
	logic [COUNT_BITS-1:0] slot_qty    [SLOTS];

	kcst_res_t table_results[$];
	int        mismatch_total = 0;

	assign mismatches = mismatch_total;

	function automatic bit key_match(input int s, input logic [TYPE_BITS-1:0] kind,
			input logic [ID_BITS-1:0] key_id);
		return slot_used[s] && slot_kind[s] == kind && slot_key_id[s] == key_id;
	endfunction

	task automatic clear_slot(input int s);
		slot_used[s]   = 1'b0;
		slot_kind[s]   = '0;
		slot_key_id[s] = '0;
		slot_qty[s]    = '0;
	endtask

	task automatic apply_to_table(input logic [CMD_BITS-1:0] cmd,
			input logic [TYPE_BITS-1:0] kind, input logic [IN_ID_BITS-1:0] id_in,
			input logic [AMT_BITS-1:0] amt, output kcst_res_t res);
		logic [ID_BITS-1:0] key_id;
		int hit;
		int empty_slot;
		int used;
		longint unsigned acc;
		longint unsigned left;
		key_id = id_in[ID_BITS-1:0];
		res.status = ST_DONE;
		res.slot_index = '0;
		res.quantity = '0;
		hit = -1;
		empty_slot = -1;
		used = 0;
		if (cmd == CMD_ADD && amt != 0) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (hit < 0 && key_match(s, kind, key_id))
					hit = s;
				if (empty_slot < 0 && !slot_used[s])
					empty_slot = s;
			end
			if (hit >= 0) begin
				acc = longint'(slot_qty[hit]) + longint'(amt);
				slot_qty[hit] = COUNT_BITS'((acc > COUNT_TOP) ? COUNT_TOP : acc);
				res.status = ST_MERGED;
				res.slot_index = INDEX_BITS'(hit);
			end else if (empty_slot >= 0) begin
				acc = longint'(amt);
				slot_used[empty_slot]   = 1'b1;
				slot_kind[empty_slot]   = kind;
				slot_key_id[empty_slot] = key_id;
				slot_qty[empty_slot]    = COUNT_BITS'((acc > COUNT_TOP) ? COUNT_TOP : acc);
				res.status = ST_NEW;
				res.slot_index = INDEX_BITS'(empty_slot);
			end else begin
				res.status = ST_FULL;
			end
		end else if (cmd == CMD_REMOVE && amt != 0) begin
			left = longint'(amt);
			for (int s = 0; s < SLOTS && left > 0; s++) begin
				if (key_match(s, kind, key_id)) begin
					if (longint'(slot_qty[s]) > left) begin
						slot_qty[s] = slot_qty[s] - COUNT_BITS'(left);
						left = 0;
					end else begin
						left = left - longint'(slot_qty[s]);
						clear_slot(s);
					end
				end
			end
			if (left > 0) begin
				res.status = ST_SHORT;
				res.quantity = QTY_BITS'(left);
			end
		end else if (cmd == CMD_QUERY) begin
			acc = 0;
			for (int s = 0; s < SLOTS; s++)
				if (key_match(s, kind, key_id))
					acc = acc + longint'(slot_qty[s]);
			res.quantity = QTY_BITS'((acc > QTY_TOP) ? QTY_TOP : acc);
		end
		for (int s = 0; s < SLOTS; s++)
			if (slot_used[s])
				used++;
		res.occupied_slots = OCC_OUT_BITS'(used);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_total++;
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		kcst_res_t want;
		kcst_res_t fresh;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				clear_slot(s);
			table_results.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (table_results.size() == 0) begin
					report_mismatch("result with no item pending", m_tuser, 0);
				end else begin
					want = table_results.pop_front();
					if (m_tuser !== want.status)
						report_mismatch("status", m_tuser, want.status);
					if (m_tdata[3:0] !== want.slot_index)
						report_mismatch("slot_index", m_tdata[3:0], want.slot_index);
					if (m_tdata[19:4] !== want.quantity)
						report_mismatch("quantity", m_tdata[19:4], want.quantity);
					if (m_tdata[24:20] !== want.occupied_slots)
						report_mismatch("occupied_slots", m_tdata[24:20],
							want.occupied_slots);
				end
			end
			if (s_tvalid && s_tready) begin
				apply_to_table(s_tuser, s_tdata[1:0], s_tdata[9:2], s_tdata[25:10], fresh);
				table_results.insert(table_results.size(), fresh);
			end
			pending <= table_results.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import kcst_pkg::*; ();

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_ITEMS = 920;
	localparam int PAUSE_AT = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [1:0]  s_tuser;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [2:0]  m_tuser;
	logic [31:0] m_tdata;
	int          pending;
	int          mismatches;
	int          idle_cycles = 0;

	keyed_count_slot_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	kcst_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata),
		.pending    (pending),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [AMT_BITS-1:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return '0;
		if (r < 70)
			return AMT_BITS'($urandom_range(1, 300));
		if (r < 85)
			return AMT_BITS'($urandom_range(301, 5000));
		if (r < 95)
			return AMT_BITS'($urandom_range(0, 65535));
		return AMT_BITS'($urandom_range(65000, 65535));
	endfunction

	// Drives the item and returns once it is taken.
	task automatic push_item(input logic [1:0] cmd, input logic [1:0] kind,
			input logic [7:0] id, input logic [15:0] amt);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'b0, amt, id, kind};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Drops s_tvalid and returns once every result is back.
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [1:0] cmd;
		logic [1:0] kind;
		logic [7:0] id;
		logic [7:0] id_pool [8];
		int r;
		bit quiet;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, ignored items, saturation, shortfall, full table.
		push_item(CMD_QUERY, 2'd0, 8'd0, 16'd0);
		hold_off(pick_gap());
		push_item(CMD_ADD, 2'd2, 8'h55, 16'd0);
		hold_off(pick_gap());
		push_item(CMD_REMOVE, 2'd1, 8'hAA, 16'd0);
		hold_off(pick_gap());
		push_item(CMD_UNUSED, 2'd3, 8'hFF, 16'hFFFF);
		hold_off(pick_gap());
		push_item(CMD_ADD, 2'd3, 8'hFF, 16'hFFFF);
		hold_off(pick_gap());
		push_item(CMD_ADD, 2'd3, 8'hFF, 16'd1);
		hold_off(pick_gap());
		push_item(CMD_QUERY, 2'd3, 8'hFF, 16'd0);
		hold_off(pick_gap());
		push_item(CMD_REMOVE, 2'd3, 8'hFF, 16'd65000);
		hold_off(pick_gap());
		push_item(CMD_REMOVE, 2'd3, 8'hFF, 16'd1000);
		for (int k = 0; k < SLOTS; k++) begin
			hold_off(pick_gap());
			push_item(CMD_ADD, 2'(k), 8'(k * 17), 16'($urandom_range(1, 65535)));
		end
		hold_off(pick_gap());
		push_item(CMD_ADD, 2'd1, 8'h42, 16'd7);
		hold_off(pick_gap());
		push_item(CMD_ADD, 2'd0, 8'd0, 16'hFFFF);
		hold_off(pick_gap());
		push_item(CMD_QUERY, 2'd0, 8'd0, 16'd0);
		hold_off(pick_gap());
		push_item(CMD_REMOVE, 2'd2, 8'd34, 16'hFFFF);

		quiet = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// A fresh key pool now and then keeps the table churning through new keys.
			if (n % 150 == 0) begin
				foreach (id_pool[i])
					id_pool[i] = 8'($urandom_range(0, 255));
				id_pool[0] = 8'd0;
				id_pool[7] = 8'hFF;
			end
			if (n % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (n == PAUSE_AT)
				wait_all_results();
			else
				hold_off(quiet ? 0 : pick_gap());
			r = $urandom_range(0, 99);
			if (r < 45)
				cmd = CMD_ADD;
			else if (r < 75)
				cmd = CMD_REMOVE;
			else if (r < 95)
				cmd = CMD_QUERY;
			else
				cmd = CMD_UNUSED;
			kind = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0)
				id = 8'($urandom_range(0, 255));
			else
				id = id_pool[$urandom_range(0, 7)];
			push_item(cmd, kind, id, pick_amount());
		end

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[keyed_count_slot_table_core] OK");
		else
			$display("[keyed_count_slot_table_core] ERROR");
		$finish;
	end

	initial begin
		int hold;
		m_tready = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 15);
			m_tready <= 1'b1;
			repeat (hold) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[keyed_count_slot_table_core] ERROR");
				$finish;
			end
		end
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/kcst_pkg.sv
sv/kcst_front.sv
sv/kcst_back.sv
sv/keyed_count_slot_table_core.sv
bench/kcst_checker.sv
bench/tb_top.sv
